// File: hw/rtl/cbre_pkg.sv
// ----------------------------------------------------------------------------
// cbre_pkg
// Item types and action codes shared by the bitmap range engine.
// ----------------------------------------------------------------------------
package cbre_pkg;

  localparam logic [2:0] ACT_FLUSH = 3'd0;
  localparam logic [2:0] ACT_RANGE = 3'd1;
  localparam logic [2:0] ACT_RDB   = 3'd2;
  localparam logic [2:0] ACT_SETB  = 3'd3;
  localparam logic [2:0] ACT_CLRB  = 3'd4;
  localparam logic [2:0] ACT_RDW   = 3'd5;
  localparam logic [2:0] ACT_CLRW  = 3'd6;

  localparam logic [4:0] SIZE_MIN   = 5'd5;
  localparam logic [4:0] SIZE_RESET = 5'd16;

  typedef struct packed {
    logic [2:0]  action;
    logic [15:0] first_bit;
    logic [15:0] last_bit;
    logic        fill_value;
    logic [15:0] bit_index;
  } req_t;

  typedef struct packed {
    logic        bit_value;
    logic [31:0] block_word;
  } rsp_t;

endpackage

// File: hw/rtl/cbre_mem.sv
// ----------------------------------------------------------------------------
// cbre_mem
// Single-port word store, one access a cycle, registered read data.
// ----------------------------------------------------------------------------
module cbre_mem #(
  parameter int AW    = 11,
  parameter int WORDS = 2048
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] addr,
  input  logic [31:0]   wdata,
  output logic [31:0]   rdata
);

  logic [31:0] mem [WORDS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end else begin
      rdata <= mem[addr];
    end
  end

endmodule

// File: hw/rtl/cbre_regs.sv
// ----------------------------------------------------------------------------
// cbre_regs
// APB register file holding the map size setting.
// ----------------------------------------------------------------------------
module cbre_regs (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic [4:0]  size_log2
);
  import cbre_pkg::*;

  logic reg_hit;

  assign pready  = 1'b1;
  assign reg_hit = (paddr[2] == 1'b0);
  assign prdata  = reg_hit ? {27'd0, size_log2} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      size_log2 <= SIZE_RESET;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      size_log2 <= pwdata[4:0];
    end
  end

endmodule

// File: hw/rtl/cbre_seq.sv
// ----------------------------------------------------------------------------
// cbre_seq
// Action sequencer: read-modify-write over the word store, range walks,
// clearing sweeps and the result register.
// ----------------------------------------------------------------------------
module cbre_seq #(
  parameter int LG    = 16,
  parameter int AW    = 11,
  parameter int WORDS = 2048
) (
  input  logic            clk,
  input  logic            rst,
  input  logic [4:0]      size_log2,
  input  logic            req_valid,
  output logic            req_stall,
  input  cbre_pkg::req_t  req,
  output logic            rsp_valid,
  input  logic            rsp_stall,
  output cbre_pkg::rsp_t  rsp,
  output logic            mem_we,
  output logic [AW-1:0]   mem_addr,
  output logic [31:0]     mem_wdata,
  input  logic [31:0]     mem_rdata
);
  import cbre_pkg::*;

  localparam logic [2:0] ST_CLR  = 3'd0;
  localparam logic [2:0] ST_IDLE = 3'd1;
  localparam logic [2:0] ST_RD   = 3'd2;
  localparam logic [2:0] ST_WR   = 3'd3;
  localparam logic [2:0] ST_DONE = 3'd4;

  localparam logic [AW-1:0] LAST_W = AW'(WORDS - 1);
  localparam logic [4:0]    SIZE_MAX = 5'(LG);

  logic [2:0]    state, state_next;
  logic [2:0]    act, act_next;
  logic          fill, fill_next;
  logic [AW-1:0] cur_w, cur_w_next;
  logic [AW-1:0] start_w, start_w_next;
  logic [AW-1:0] end_w, end_w_next;
  logic [4:0]    lo_off, lo_off_next;
  logic [4:0]    hi_off, hi_off_next;
  logic          seg2, seg2_next;
  logic [15:0]   b2, b2_next;
  logic          clr_rsp, clr_rsp_next;
  logic          res_bit, res_bit_next;
  logic [31:0]   res_word, res_word_next;
  logic          rsp_valid_next;
  rsp_t          rsp_next;

  logic [4:0]  s_eff;
  logic [15:0] mask;
  logic [15:0] m_first, m_last, m_bit, m_hi;
  logic        wrap, finish, rsp_free;
  logic [31:0] sel, rmask;
  logic [4:0]  lo_use, hi_use;

  always_comb begin
    if (size_log2 < SIZE_MIN) begin
      s_eff = SIZE_MIN;
    end else if (size_log2 > SIZE_MAX) begin
      s_eff = SIZE_MAX;
    end else begin
      s_eff = size_log2;
    end
  end

  assign mask    = 16'((17'd1 << s_eff) - 17'd1);
  assign m_first = req.first_bit & mask;
  assign m_last  = req.last_bit & mask;
  assign m_bit   = req.bit_index & mask;
  assign wrap    = (m_last < m_first);
  assign m_hi    = wrap ? mask : m_last;

  assign lo_use = (cur_w == start_w) ? lo_off : 5'd0;
  assign hi_use = (cur_w == end_w) ? hi_off : 5'd31;
  assign rmask  = (32'hFFFF_FFFF >> lo_use) & (32'hFFFF_FFFF << (5'd31 - hi_use));
  assign sel    = 32'h8000_0000 >> lo_off;

  assign rsp_free  = !rsp_valid || !rsp_stall;
  assign req_stall = (state != ST_IDLE);

  always_comb begin
    state_next    = state;
    act_next      = act;
    fill_next     = fill;
    cur_w_next    = cur_w;
    start_w_next  = start_w;
    end_w_next    = end_w;
    lo_off_next   = lo_off;
    hi_off_next   = hi_off;
    seg2_next     = seg2;
    b2_next       = b2;
    clr_rsp_next  = clr_rsp;
    res_bit_next  = res_bit;
    res_word_next = res_word;
    mem_we        = 1'b0;
    mem_addr      = cur_w;
    mem_wdata     = 32'd0;
    finish        = 1'b0;

    case (state)
      ST_CLR: begin
        mem_we = 1'b1;
        if (cur_w == LAST_W) begin
          if (clr_rsp) begin
            finish = 1'b1;
          end else begin
            state_next = ST_IDLE;
          end
        end else begin
          cur_w_next = cur_w + AW'(1);
        end
      end
      ST_IDLE: begin
        if (req_valid) begin
          act_next      = req.action;
          fill_next     = req.fill_value;
          res_bit_next  = 1'b0;
          res_word_next = 32'd0;
          seg2_next     = 1'b0;
          b2_next       = m_last;
          case (req.action)
            ACT_FLUSH: begin
              cur_w_next   = '0;
              clr_rsp_next = 1'b1;
              state_next   = ST_CLR;
            end
            ACT_RANGE: begin
              cur_w_next   = m_first[AW+4:5];
              start_w_next = m_first[AW+4:5];
              lo_off_next  = m_first[4:0];
              end_w_next   = m_hi[AW+4:5];
              hi_off_next  = m_hi[4:0];
              seg2_next    = wrap;
              state_next   = ST_RD;
            end
            ACT_RDB, ACT_SETB, ACT_CLRB, ACT_RDW, ACT_CLRW: begin
              cur_w_next  = m_bit[AW+4:5];
              lo_off_next = m_bit[4:0];
              state_next  = ST_RD;
            end
            default: begin
              state_next = ST_DONE;
            end
          endcase
        end
      end
      ST_RD: begin
        state_next = ST_WR;
      end
      ST_WR: begin
        case (act)
          ACT_RANGE: begin
            mem_we    = 1'b1;
            mem_wdata = fill ? (mem_rdata | rmask) : (mem_rdata & ~rmask);
            if (cur_w == end_w) begin
              if (seg2) begin
                seg2_next    = 1'b0;
                cur_w_next   = '0;
                start_w_next = '0;
                lo_off_next  = 5'd0;
                end_w_next   = b2[AW+4:5];
                hi_off_next  = b2[4:0];
                state_next   = ST_RD;
              end else begin
                finish = 1'b1;
              end
            end else begin
              cur_w_next = cur_w + AW'(1);
              state_next = ST_RD;
            end
          end
          ACT_SETB: begin
            mem_we    = 1'b1;
            mem_wdata = mem_rdata | sel;
            finish    = 1'b1;
          end
          ACT_CLRB: begin
            mem_we    = 1'b1;
            mem_wdata = mem_rdata & ~sel;
            finish    = 1'b1;
          end
          ACT_CLRW: begin
            mem_we = 1'b1;
            finish = 1'b1;
          end
          ACT_RDB: begin
            res_bit_next = |(mem_rdata & sel);
            finish       = 1'b1;
          end
          ACT_RDW: begin
            res_word_next = mem_rdata;
            finish        = 1'b1;
          end
          default: begin
            finish = 1'b1;
          end
        endcase
      end
      ST_DONE: begin
        finish = 1'b1;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase

    rsp_valid_next = rsp_valid && rsp_stall;
    rsp_next       = rsp;
    if (finish) begin
      if (rsp_free) begin
        rsp_valid_next      = 1'b1;
        rsp_next.bit_value  = res_bit_next;
        rsp_next.block_word = res_word_next;
        clr_rsp_next        = 1'b0;
        state_next          = ST_IDLE;
      end else begin
        state_next = ST_DONE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLR;
      cur_w     <= '0;
      clr_rsp   <= 1'b0;
      seg2      <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cur_w     <= cur_w_next;
      clr_rsp   <= clr_rsp_next;
      seg2      <= seg2_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    act      <= act_next;
    fill     <= fill_next;
    start_w  <= start_w_next;
    end_w    <= end_w_next;
    lo_off   <= lo_off_next;
    hi_off   <= hi_off_next;
    b2       <= b2_next;
    res_bit  <= res_bit_next;
    res_word <= res_word_next;
    rsp      <= rsp_next;
  end

endmodule

// File: hw/rtl/circular_bitmap_range_engine.sv
// ----------------------------------------------------------------------------
// circular_bitmap_range_engine
// Wrapping bit map of MAP_BITS bits held as 32-bit words in one memory.
// ----------------------------------------------------------------------------
// One item is taken at a time; each gives exactly one result. Every word
// touched is read and then written on the single-port word memory, but
// bit and word reads only read and a flush only writes, one word cleared a
// cycle; a range action touches every word of its span, both pieces when it
// wraps. After reset the memory is cleared by the same sweep, all
// MAP_BITS/32 words (2048 at the default size), with req_stall high. The
// result register lets the next item be taken while a result waits. A
// MAP_BITS that is not a power of two is rounded down to one, and the word
// counts above follow it.
module circular_bitmap_range_engine #(
  parameter int MAP_BITS = 65536
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_stall,
  input  cbre_pkg::req_t  req,
  output logic            rsp_valid,
  input  logic            rsp_stall,
  output cbre_pkg::rsp_t  rsp,
  input  logic            psel,
  input  logic            penable,
  input  logic            pwrite,
  input  logic [2:0]      paddr,
  input  logic [31:0]     pwdata,
  output logic [31:0]     prdata,
  output logic            pready
);
  import cbre_pkg::*;

  localparam int LG    = $clog2(MAP_BITS + 1) - 1;
  localparam int AW    = (LG > 5) ? LG - 5 : 1;
  localparam int WORDS = 1 << (LG - 5);

  logic [4:0]    size_log2;
  logic          mem_we;
  logic [AW-1:0] mem_addr;
  logic [31:0]   mem_wdata;
  logic [31:0]   mem_rdata;

  cbre_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .size_log2 (size_log2)
  );

  cbre_mem #(
    .AW    (AW),
    .WORDS (WORDS)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  cbre_seq #(
    .LG    (LG),
    .AW    (AW),
    .WORDS (WORDS)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .size_log2 (size_log2),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .mem_we    (mem_we),
    .mem_addr  (mem_addr),
    .mem_wdata (mem_wdata),
    .mem_rdata (mem_rdata)
  );

endmodule

// File: hw/rtl/cbre_checker.sv
// ----------------------------------------------------------------------------
// cbre_checker
// Port-level checks on the bitmap range engine, bound to the top level.
// ----------------------------------------------------------------------------
module cbre_checker (
  input logic            clk,
  input logic            rst,
  input logic            req_valid,
  input logic            req_stall,
  input logic            rsp_valid,
  input logic            rsp_stall,
  input cbre_pkg::rsp_t  rsp
);
  import cbre_pkg::*;

  a_clear_after_reset: assert property (@(posedge clk)
    rst |=> req_stall)
    else $error("request side open during clearing sweep");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall) |=> req_stall)
    else $error("second item taken before the first finished");

  a_no_instant_result: assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall) |=> !$rose(rsp_valid))
    else $error("result appeared one cycle after acceptance");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp)))
    else $error("stalled result changed");

endmodule

bind circular_bitmap_range_engine cbre_checker u_cbre_checker (.*);

// File: dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the circular bitmap range engine.
// ----------------------------------------------------------------------------
// A short table of directed actions runs at the reset size. It covers the
// map ends, wrapping ranges, the full-map range, flush and the unused action
// code. Random actions follow over a series of map sizes, some of them out
// of range and so saturated. Every accepted item is run through a bit-exact
// model of the word store, and each result is compared field by field with
// the oldest expected one. Both sides idle at random, the receiver holds
// off once for a long stretch, and the size register is rewritten only
// once the engine has drained.
// ----------------------------------------------------------------------------
module tb_top;
  import cbre_pkg::*;

  localparam logic [2:0] ACT_NONE      = 3'd7;
  localparam logic [2:0] REG_SIZE_LOG2 = 3'd0;
  localparam int MAP_LOG2       = 16;
  localparam int WORDS          = 2048;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_WAIT     = 2100;
  localparam int HOLD_CYCLES    = 400;
  localparam int DIR_ROWS       = 25;
  localparam int PHASES         = 8;

  typedef struct packed {
    logic [2:0]  act;
    logic [15:0] first_bit;
    logic [15:0] last_bit;
    logic        fill_value;
    logic [15:0] bit_index;
    logic        fixed;
    logic        want_bit;
    logic [31:0] want_word;
  } dir_row_t;

  localparam dir_row_t DIR_TAB [DIR_ROWS] = '{
    '{ACT_RDB,   16'h0000, 16'h0000, 1'b0, 16'h0000, 1'b1, 1'b0, 32'h0000_0000},
    '{ACT_RDW,   16'h0000, 16'h0000, 1'b0, 16'hFFFF, 1'b1, 1'b0, 32'h0000_0000},
    '{ACT_SETB,  16'h0000, 16'h0000, 1'b0, 16'h0000, 1'b0, 1'b0, 32'h0000_0000},
    '{ACT_RDW,   16'h0000, 16'h0000, 1'b0, 16'h0005, 1'b1, 1'b0, 32'h8000_0000},
    '{ACT_SETB,  16'h0000, 16'h0000, 1'b0, 16'hFFFF, 1'b0, 1'b0, 32'h0000_0000},
    '{ACT_RDW,   16'h0000, 16'h0000, 1'b0, 16'hFFE0, 1'b1, 1'b0, 32'h0000_0001},
    '{ACT_RDB,   16'h0000, 16'h0000, 1'b0, 16'hFFFF, 1'b1, 1'b1, 32'h0000_0000},
    '{ACT_RANGE, 16'hFFF0, 16'h000F, 1'b1, 16'h0000, 1'b0, 1'b0, 32'h0000_0000},
    '{ACT_RDW,   16'h0000, 16'h0000, 1'b0, 16'hFFE0, 1'b1, 1'b0, 32'h0000_FFFF},
    '{ACT_RDW,   16'h0000, 16'h0000, 1'b0, 16'h0000, 1'b1, 1'b0, 32'hFFFF_0000},
    '{ACT_RANGE, 16'h0004, 16'h0004, 1'b0, 16'h0000, 1'b0, 1'b0, 32'h0000_0000},
    '{ACT_RDW,   16'h0000, 16'h0000, 1'b0, 16'h0000, 1'b1, 1'b0, 32'hF7FF_0000},
    '{ACT_CLRB,  16'h0000, 16'h0000, 1'b0, 16'h0000, 1'b0, 1'b0, 32'h0000_0000},
    '{ACT_RDB,   16'h0000, 16'h0000, 1'b0, 16'h0000, 1'b1, 1'b0, 32'h0000_0000},
    '{ACT_CLRW,  16'h0000, 16'h0000, 1'b0, 16'hFFE0, 1'b0, 1'b0, 32'h0000_0000},
    '{ACT_RDW,   16'h0000, 16'h0000, 1'b0, 16'hFFFF, 1'b1, 1'b0, 32'h0000_0000},
    '{ACT_NONE,  16'hFFFF, 16'hFFFF, 1'b1, 16'hFFFF, 1'b1, 1'b0, 32'h0000_0000},
    '{ACT_RANGE, 16'h0000, 16'hFFFF, 1'b1, 16'h0000, 1'b0, 1'b0, 32'h0000_0000},
    '{ACT_RDB,   16'h0000, 16'h0000, 1'b0, 16'h1234, 1'b1, 1'b1, 32'h0000_0000},
    '{ACT_RDW,   16'h0000, 16'h0000, 1'b0, 16'h8000, 1'b1, 1'b0, 32'hFFFF_FFFF},
    '{ACT_FLUSH, 16'h0000, 16'h0000, 1'b0, 16'h0000, 1'b0, 1'b0, 32'h0000_0000},
    '{ACT_RDW,   16'h0000, 16'h0000, 1'b0, 16'h8000, 1'b1, 1'b0, 32'h0000_0000},
    '{ACT_RANGE, 16'h0021, 16'h0040, 1'b1, 16'h0000, 1'b0, 1'b0, 32'h0000_0000},
    '{ACT_RANGE, 16'h0030, 16'h0022, 1'b0, 16'h0000, 1'b0, 1'b0, 32'h0000_0000},
    '{ACT_RDW,   16'h0000, 16'h0000, 1'b0, 16'h0020, 1'b0, 1'b0, 32'h0000_0000}
  };

  localparam logic [4:0] PH_SIZE  [PHASES] = '{5'd5, 5'd3, 5'd8, 5'd31, 5'd10, 5'd12, 5'd0,
                                               5'd16};
  localparam int         PH_ITEMS [PHASES] = '{300, 150, 300, 100, 300, 250, 150, 275};

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        req_valid = 1'b0;
  logic        req_stall;
  req_t        req       = '0;
  logic        rsp_valid;
  logic        rsp_stall = 1'b0;
  rsp_t        rsp;
  logic        psel      = 1'b0;
  logic        penable   = 1'b0;
  logic        pwrite    = 1'b0;
  logic [2:0]  paddr     = '0;
  logic [31:0] pwdata    = '0;
  logic [31:0] prdata;
  logic        pready;

  logic [31:0] map_words [WORDS];
  logic [4:0]  size_reg = SIZE_RESET;
  rsp_t        result_q [$];
  logic        item_fixed = 1'b0;
  rsp_t        item_want  = '0;

  int err_cnt    = 0;
  int n_items    = 0;
  int n_results  = 0;
  int n_wraps    = 0;
  int idle_run   = 0;
  int idle_pct   = 20;
  int hold_asked = 0;
  int hold_done  = 0;
  int hold_left  = 0;
  int act_cnt [8];

  circular_bitmap_range_engine DUT (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always #5 clk = ~clk;

  function automatic logic [15:0] size_mask(input logic [4:0] s);
    int e;
    e = s;
    if (e < SIZE_MIN) e = SIZE_MIN;
    if (e > MAP_LOG2) e = MAP_LOG2;
    return 16'((32'd1 << e) - 1);
  endfunction

  function automatic logic [15:0] pick_bit(input logic [15:0] m, input logic [15:0] base);
    logic [15:0] r;
    r = 16'($urandom);
    if ($urandom_range(0, 4) != 0)
      r = (r & ~m) | ((base + 16'($urandom_range(0, 255))) & m);
    return r;
  endfunction

  task automatic report_mismatch(input string what);
    err_cnt++;
    $display("[%0t] mismatch: %s", $time, what);
  endtask

  task automatic fill_span(input logic [15:0] lo, input logic [15:0] hi, input logic ones);
    int w;
    logic [31:0] pm;
    for (w = lo[15:5]; w <= hi[15:5]; w++) begin
      pm = 32'hFFFF_FFFF;
      if (w == lo[15:5]) pm &= 32'hFFFF_FFFF >> lo[4:0];
      if (w == hi[15:5]) pm &= 32'hFFFF_FFFF << (31 - hi[4:0]);
      map_words[w] = ones ? (map_words[w] | pm) : (map_words[w] & ~pm);
    end
  endtask

  task automatic apply_item(input req_t r, output rsp_t res);
    logic [15:0] m;
    logic [15:0] lo;
    logic [15:0] hi;
    logic [15:0] b;
    logic [31:0] sel;
    m   = size_mask(size_reg);
    lo  = r.first_bit & m;
    hi  = r.last_bit & m;
    b   = r.bit_index & m;
    sel = 32'h8000_0000 >> b[4:0];
    res = '0;
    case (r.action)
      ACT_FLUSH: foreach (map_words[i]) map_words[i] = '0;
      ACT_RANGE: begin
        if (hi < lo) begin
          n_wraps++;
          fill_span(lo, m, r.fill_value);
          fill_span(16'h0000, hi, r.fill_value);
        end else begin
          fill_span(lo, hi, r.fill_value);
        end
      end
      ACT_RDB:  res.bit_value = |(map_words[b[15:5]] & sel);
      ACT_SETB: map_words[b[15:5]] = map_words[b[15:5]] | sel;
      ACT_CLRB: map_words[b[15:5]] = map_words[b[15:5]] & ~sel;
      ACT_RDW:  res.block_word = map_words[b[15:5]];
      ACT_CLRW: map_words[b[15:5]] = '0;
      default: ;
    endcase
  endtask

  task automatic send_item(input req_t r, input logic fixed, input rsp_t want);
    while ($urandom_range(0, 99) < idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid  <= 1'b1;
    req        <= r;
    item_fixed <= fixed;
    item_want  <= want;
    do @(posedge clk); while (req_stall);
  endtask

  always @(posedge clk) begin
    if (hold_done < hold_asked) begin
      hold_done <= hold_done + 1;
      hold_left <= HOLD_CYCLES;
      rsp_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      rsp_stall <= 1'b1;
    end else begin
      rsp_stall <= ($urandom_range(0, 99) < idle_pct);
    end
  end

  always @(posedge clk) begin : check_results
    rsp_t want;
    logic moved;
    moved = 1'b0;
    if (!rst && rsp_valid && !rsp_stall) begin
      moved = 1'b1;
      if (result_q.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with nothing outstanding", n_results));
      end else begin
        want = result_q.pop_front();
        if (rsp.bit_value !== want.bit_value)
          report_mismatch($sformatf("result %0d bit_value %b, want %b",
                                    n_results, rsp.bit_value, want.bit_value));
        if (rsp.block_word !== want.block_word)
          report_mismatch($sformatf("result %0d block_word %h, want %h",
                                    n_results, rsp.block_word, want.block_word));
      end
      n_results++;
    end
    if (!rst && req_valid && !req_stall) begin
      moved = 1'b1;
      apply_item(req, want);
      if (item_fixed) want = item_want;
      result_q.push_back(want);
      act_cnt[req.action]++;
      n_items++;
    end
    if (moved) idle_run = 0;
    else idle_run++;
    if (idle_run >= WATCHDOG_LIMIT) begin
      $display("watchdog: no item moved for %0d cycles", WATCHDOG_LIMIT);
      $display("FAILURE");
      $finish;
    end
  end

  initial begin : stimulus
    req_t        r;
    rsp_t        want;
    logic [15:0] m;
    logic [15:0] base;
    int          p;
    foreach (map_words[i]) map_words[i] = '0;
    foreach (act_cnt[i]) act_cnt[i] = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < DIR_ROWS; i++) begin
      r.action          = DIR_TAB[i].act;
      r.first_bit       = DIR_TAB[i].first_bit;
      r.last_bit        = DIR_TAB[i].last_bit;
      r.fill_value      = DIR_TAB[i].fill_value;
      r.bit_index       = DIR_TAB[i].bit_index;
      want.bit_value    = DIR_TAB[i].want_bit;
      want.block_word   = DIR_TAB[i].want_word;
      send_item(r, DIR_TAB[i].fixed, want);
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      // drain, then let any sweep finish before touching the size register
      req_valid <= 1'b0;
      @(posedge clk);
      while (result_q.size() != 0) @(posedge clk);
      repeat (DRAIN_WAIT) @(posedge clk);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= REG_SIZE_LOG2;
      pwdata  <= {27'($urandom), PH_SIZE[ph]};
      @(posedge clk);
      penable <= 1'b1;
      do @(posedge clk); while (!pready);
      psel     <= 1'b0;
      penable  <= 1'b0;
      pwrite   <= 1'b0;
      size_reg  = PH_SIZE[ph];

      m    = size_mask(size_reg);
      base = 16'($urandom);
      for (int k = 0; k < PH_ITEMS[ph]; k++) begin
        if (ph == 1 && k == 60) hold_asked++;
        if (ph == 2) idle_pct = (k >= 100 && k < 250) ? 0 : 20;
        if (ph == 3 && k == 50) begin
          req_valid <= 1'b0;
          @(posedge clk);
          while (result_q.size() != 0) @(posedge clk);
          @(posedge clk);
        end
        p = $urandom_range(0, 99);
        if (p < 2) r.action = ACT_FLUSH;
        else if (p < 24) r.action = ACT_RANGE;
        else if (p < 40) r.action = ACT_RDB;
        else if (p < 54) r.action = ACT_SETB;
        else if (p < 64) r.action = ACT_CLRB;
        else if (p < 82) r.action = ACT_RDW;
        else if (p < 96) r.action = ACT_CLRW;
        else r.action = ACT_NONE;
        r.first_bit = pick_bit(m, base);
        if ($urandom_range(0, 19) == 0)
          r.last_bit = 16'($urandom);
        else
          r.last_bit = (16'($urandom) & ~m) |
                       ((r.first_bit + 16'($urandom_range(0, 95))) & m);
        r.fill_value = 1'($urandom);
        r.bit_index  = pick_bit(m, base);
        send_item(r, 1'b0, '0);
      end
    end

    req_valid <= 1'b0;
    @(posedge clk);
    while (result_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);

    $display("covered %0d items over %0d size settings: %0d range (%0d wrapping), %0d flush,",
             n_items, PHASES + 1, act_cnt[ACT_RANGE], n_wraps, act_cnt[ACT_FLUSH]);
    $display("%0d bit reads, %0d word reads, %0d unused code; %0d results, %0d mismatches",
             act_cnt[ACT_RDB], act_cnt[ACT_RDW], act_cnt[ACT_NONE], n_results, err_cnt);
    if (err_cnt == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
